/* hdl/lla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg
// Shared constants, register indexes and controller/datapath handshake types
// of the leaky LMS adaptive FIR.
// ----------------------------------------------------------------------------
package lla_pkg;

  localparam int TAPS_DEF        = 32;
  localparam int LINE_DEPTH_DEF  = 40;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_FRAC = 30;
  localparam int GAIN_FRAC = 16;
  localparam int COEF_W    = 32;

  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] STEP_SIZE_RST   = REG_W'(655);
  localparam logic [REG_W-1:0] LEAK_FACTOR_RST = REG_W'(64880);

  typedef struct packed {
    logic clr_acc;
    logic start_pass;
    logic issue;
    logic upd;
    logic ld_y;
    logic ld_emu;
    logic ld_g;
    logic ld_out;
    logic shift;
  } lla_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } lla_sts_t;

endpackage

/* hdl/lla_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_sample_if
// Sample request channel: valid/ready with one signed sample.
// ----------------------------------------------------------------------------
interface lla_sample_if #(
  parameter int SAMPLE_BITS = lla_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* hdl/lla_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_result_if
// Result request channel: valid/ready with one filtered output sample.
// ----------------------------------------------------------------------------
interface lla_result_if #(
  parameter int SAMPLE_BITS = lla_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

/* hdl/lla_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_datapath
// Delay line and weight memories, shared tap multiplier, accumulator, error
// and gain path, and the pipelined leaky weight update.
// ----------------------------------------------------------------------------
module lla_datapath #(
  parameter int TAPS        = lla_pkg::TAPS_DEF,
  parameter int LINE_DEPTH  = lla_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = lla_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lla_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lla_pkg::REG_W-1:0]           cfg_data_i,
  input  logic                                in_fire_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  input  lla_pkg::lla_cmd_t                   cmd_i,
  input  logic [$clog2(TAPS)-1:0]             tap_i,
  output lla_pkg::lla_sts_t                   sts_o,
  output logic signed [SAMPLE_BITS-1:0]       filtered_out_o
);
  import lla_pkg::*;

  localparam int S    = SAMPLE_BITS;
  localparam int K_W  = $clog2(TAPS);
  localparam int LP_W = $clog2(LINE_DEPTH);
  localparam int P_W  = S + COEF_W;
  localparam int A_W  = S + COEF_W + $clog2(TAPS);
  localparam int E_W  = S + 1;
  localparam int M_W  = E_W + REG_W + 1;
  localparam int G_W  = S + 2;
  localparam int PROD_FRAC = 2 * (S - 1);
  localparam int RSH  = (PROD_FRAC > COEF_FRAC) ? PROD_FRAC - COEF_FRAC : 0;
  localparam int LSH  = (PROD_FRAC < COEF_FRAC) ? COEF_FRAC - PROD_FRAC : 0;
  localparam int GP_W = G_W + S;
  localparam int D_W  = GP_W + LSH;
  localparam int S_W  = ((D_W > COEF_W) ? D_W : COEF_W) + 1;
  localparam int L_W  = S_W + REG_W + 1;

  localparam logic signed [A_W:0] Y_HALF = (A_W+1)'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [A_W:0] Y_MAX  = {{(A_W-S+2){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [A_W:0] Y_MIN  = {{(A_W-S+2){1'b1}}, {(S-1){1'b0}}};
  localparam logic signed [M_W:0] G_HALF = (M_W+1)'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [L_W:0] W_HALF = (L_W+1)'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [L_W:0] W_MAX  = {{(L_W-30){1'b0}}, {31{1'b1}}};
  localparam logic signed [L_W:0] W_MIN  = {{(L_W-30){1'b1}}, {31{1'b0}}};

  // configuration
  logic [REG_W-1:0] step_q, leak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_SIZE_RST;
      leak_q <= LEAK_FACTOR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STEP_SIZE) begin
        step_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_LEAK_FACTOR) begin
        leak_q <= cfg_data_i;
      end
    end
  end

  // delay line as a circular buffer
  logic signed [S-1:0]     lmem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0]   lvld_q;
  logic [LP_W-1:0]         base_q, rp_q, wr_ptr, base_nxt, rp_nxt;
  logic                    tap_in;

  assign wr_ptr   = (base_q == '0) ? LP_W'(LINE_DEPTH - 1) : base_q - LP_W'(1);
  assign base_nxt = (base_q == LP_W'(LINE_DEPTH - 1)) ? '0 : base_q + LP_W'(1);
  assign rp_nxt   = (rp_q == LP_W'(LINE_DEPTH - 1)) ? '0 : rp_q + LP_W'(1);
  assign tap_in   = 32'(tap_i) < 32'(LINE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      rp_q   <= '0;
      lvld_q <= '0;
    end else begin
      if (in_fire_i) begin
        lvld_q[wr_ptr] <= 1'b1;
      end
      if (cmd_i.shift) begin
        base_q <= base_nxt;
      end
      if (cmd_i.start_pass) begin
        rp_q <= base_q;
      end else if (cmd_i.issue) begin
        rp_q <= rp_nxt;
      end
    end
  end

  // weight memory
  logic signed [COEF_W-1:0] wmem [TAPS];
  logic [TAPS-1:0]          wvld_q;

  // stage 1: registered memory reads
  logic signed [S-1:0]      x_q;
  logic signed [COEF_W-1:0] w_q;
  logic                     xv_q, wv_q, s1_v_q, s1_upd_q;
  logic [K_W-1:0]           k1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      lmem[wr_ptr] <= sample_in_i;
    end
    if (cmd_i.issue) begin
      x_q <= lmem[rp_q];
    end
  end

  // stage 2: shared multiplier
  logic signed [S-1:0]      x1;
  logic signed [COEF_W-1:0] w1, mb;
  logic signed [P_W-1:0]    m_d, m_q;
  logic signed [COEF_W-1:0] w2_q;
  logic [K_W-1:0]           k2_q;
  logic                     m_v_q, m_upd_q;
  logic signed [G_W-1:0]    g_q;

  assign x1  = xv_q ? x_q : '0;
  assign w1  = wv_q ? w_q : '0;
  assign mb  = s1_upd_q ? COEF_W'(g_q) : w1;
  assign m_d = P_W'(x1) * P_W'(mb);

  // stage 3: gradient alignment, leak product
  logic signed [GP_W-1:0]   p_s;
  logic signed [D_W-1:0]    d_s;
  logic signed [S_W-1:0]    sum_s;
  logic signed [REG_W:0]    lk;
  logic signed [L_W-1:0]    l_d, l_q;
  logic [K_W-1:0]           k3_q;
  logic                     l_v_q;

  assign p_s = $signed(m_q[GP_W-1:0]);

  if (RSH > 0) begin : g_rsh
    localparam logic signed [GP_W:0] P_HALF = (GP_W+1)'(1) <<< (RSH - 1);
    logic signed [GP_W:0] p_rnd;
    assign p_rnd = (GP_W+1)'(p_s) + P_HALF;
    assign d_s   = D_W'(p_rnd >>> RSH);
  end else begin : g_lsh
    assign d_s = D_W'(p_s) <<< LSH;
  end

  assign sum_s = S_W'(w2_q) + S_W'(d_s);
  assign lk    = $signed({1'b0, leak_q});
  assign l_d   = L_W'(sum_s) * L_W'(lk);

  // stage 4: round, saturate, write back
  logic signed [L_W:0]      w_rnd, w_sh;
  logic signed [COEF_W-1:0] w_new;

  assign w_rnd = (L_W+1)'(l_q) + W_HALF;
  assign w_sh  = w_rnd >>> GAIN_FRAC;

  always_comb begin
    if (w_sh > W_MAX) begin
      w_new = {1'b0, {(COEF_W-1){1'b1}}};
    end else if (w_sh < W_MIN) begin
      w_new = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      w_new = w_sh[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      w_q <= wmem[tap_i];
    end
    if (l_v_q) begin
      wmem[k3_q] <= w_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q   <= '0;
      s1_v_q   <= 1'b0;
      s1_upd_q <= 1'b0;
      m_v_q    <= 1'b0;
      m_upd_q  <= 1'b0;
      l_v_q    <= 1'b0;
    end else begin
      s1_v_q   <= cmd_i.issue;
      s1_upd_q <= cmd_i.upd;
      m_v_q    <= s1_v_q;
      m_upd_q  <= s1_upd_q;
      l_v_q    <= m_v_q & m_upd_q;
      if (l_v_q) begin
        wvld_q[k3_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      xv_q <= lvld_q[rp_q] & tap_in;
      wv_q <= wvld_q[tap_i];
      k1_q <= tap_i;
    end
    m_q  <= m_d;
    w2_q <= w1;
    k2_q <= k1_q;
    l_q  <= l_d;
    k3_q <= k2_q;
  end

  // accumulator, output, error and gain
  logic signed [A_W-1:0] acc_q;
  logic signed [A_W:0]   acc_rnd, y_sh;
  logic signed [S-1:0]   y_c, y_q, x0_q, out_q;
  logic signed [E_W-1:0] e_q;
  logic signed [M_W-1:0] emu_q;
  logic signed [M_W:0]   g_rnd;

  assign acc_rnd = (A_W+1)'(acc_q) + Y_HALF;
  assign y_sh    = acc_rnd >>> COEF_FRAC;
  assign g_rnd   = (M_W+1)'(emu_q) + G_HALF;

  always_comb begin
    if (y_sh > Y_MAX) begin
      y_c = {1'b0, {(S-1){1'b1}}};
    end else if (y_sh < Y_MIN) begin
      y_c = {1'b1, {(S-1){1'b0}}};
    end else begin
      y_c = y_sh[S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (m_v_q && !m_upd_q) begin
      acc_q <= acc_q + A_W'(m_q);
    end
    if (s1_v_q && !s1_upd_q && k1_q == '0) begin
      x0_q <= x1;
    end
    if (cmd_i.ld_y) begin
      y_q <= y_c;
      e_q <= E_W'(x0_q) - E_W'(y_c);
    end
    if (cmd_i.ld_emu) begin
      emu_q <= M_W'(e_q) * M_W'($signed({1'b0, step_q}));
    end
    if (cmd_i.ld_g) begin
      g_q <= G_W'(g_rnd >>> GAIN_FRAC);
    end
    if (cmd_i.ld_out) begin
      out_q <= y_q;
    end
  end

  assign filtered_out_o  = out_q;
  assign sts_o.pipe_busy = s1_v_q | m_v_q | l_v_q;

endmodule

/* hdl/lla_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_ctrl
// Sequencer: filter pass, error and gain steps, weight update pass, and the
// output register handshake.
// ----------------------------------------------------------------------------
module lla_ctrl #(
  parameter int TAPS = lla_pkg::TAPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    out_ready_i,
  input  lla_pkg::lla_sts_t       sts_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output lla_pkg::lla_cmd_t       cmd_o,
  output logic [$clog2(TAPS)-1:0] tap_o
);
  import lla_pkg::*;

  localparam int K_W = $clog2(TAPS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FILT   = 4'd1;
  localparam logic [3:0] ST_FDRAIN = 4'd2;
  localparam logic [3:0] ST_Y      = 4'd3;
  localparam logic [3:0] ST_MU     = 4'd4;
  localparam logic [3:0] ST_G      = 4'd5;
  localparam logic [3:0] ST_UPD    = 4'd6;
  localparam logic [3:0] ST_UDRAIN = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [K_W-1:0] tap_q, tap_d;
  logic           out_valid_q, out_valid_d;
  logic           last_tap;

  assign last_tap = tap_q == K_W'(TAPS - 1);

  always_comb begin
    state_d     = state_q;
    tap_d       = tap_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.clr_acc    = 1'b1;
          cmd_o.start_pass = 1'b1;
          tap_d            = '0;
          state_d          = ST_FILT;
        end
      end
      ST_FILT: begin
        cmd_o.issue = 1'b1;
        tap_d       = tap_q + K_W'(1);
        if (last_tap) begin
          state_d = ST_FDRAIN;
        end
      end
      ST_FDRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_Y;
        end
      end
      ST_Y: begin
        cmd_o.ld_y = 1'b1;
        state_d    = ST_MU;
      end
      ST_MU: begin
        cmd_o.ld_emu = 1'b1;
        state_d      = ST_G;
      end
      ST_G: begin
        cmd_o.ld_g       = 1'b1;
        cmd_o.start_pass = 1'b1;
        tap_d            = '0;
        state_d          = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.issue = 1'b1;
        cmd_o.upd   = 1'b1;
        tap_d       = tap_q + K_W'(1);
        if (last_tap) begin
          state_d = ST_UDRAIN;
        end
      end
      ST_UDRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          cmd_o.shift  = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign tap_o       = tap_q;

endmodule

/* hdl/leaky_lms_adaptive_fir.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_lms_adaptive_fir
// Accepts one sample at a time: a new sample is taken only once the result of
// the last has been loaded into the output register, since the single shared
// tap multiplier does TAPS filter products then TAPS weight updates.
// Reset: step size 655, leak 64880; delay line and weights read as zero
// through per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module leaky_lms_adaptive_fir #(
  parameter int TAPS        = lla_pkg::TAPS_DEF,
  parameter int LINE_DEPTH  = lla_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = lla_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lla_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lla_pkg::REG_W-1:0]     cfg_data_i,
  lla_sample_if.sink                    sample_i,
  lla_result_if.source                  result_o
);
  import lla_pkg::*;

  lla_cmd_t                cmd;
  lla_sts_t                sts;
  logic [$clog2(TAPS)-1:0] tap;
  logic                    in_fire;

  assign in_fire = sample_i.valid & sample_i.ready;

  lla_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd),
    .tap_o       (tap)
  );

  lla_datapath #(
    .TAPS        (TAPS),
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_fire_i      (in_fire),
    .sample_in_i    (sample_i.sample_in),
    .cmd_i          (cmd),
    .tap_i          (tap),
    .sts_o          (sts),
    .filtered_out_o (result_o.filtered_out)
  );

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.ready |-> !sts.pipe_busy)
    else $error("datapath pipeline busy while accepting samples");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !sample_i.ready)
    else $error("second sample accepted while one is in work");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ld_out |-> (!result_o.valid || result_o.ready))
    else $error("pending result overwritten");

endmodule
